FILE: rtl/shsp_pkg.sv
// Package for the SCGI header stream parser: item structs and event codes.
// No dependencies; imported by every module of the block.
`default_nettype none

package shsp_pkg;

    // Event codes carried in event_kind
    localparam logic [3:0] EV_DIGIT     = 4'd0;
    localparam logic [3:0] EV_COLON     = 4'd1;
    localparam logic [3:0] EV_NAME      = 4'd2;
    localparam logic [3:0] EV_NAME_END  = 4'd3;
    localparam logic [3:0] EV_VALUE     = 4'd4;
    localparam logic [3:0] EV_VALUE_END = 4'd5;
    localparam logic [3:0] EV_DONE      = 4'd6;
    localparam logic [3:0] EV_ERROR     = 4'd7;
    localparam logic [3:0] EV_IGNORED   = 4'd8;

    // Characters the parser looks for
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Configuration register map
    localparam int unsigned     CFG_ADDR_W = 3;
    localparam logic [16:0]     MAX_LEN_RESET = 17'h10000;
    localparam logic            REG_MAX_LEN = 1'b0;   // word index (paddr[2])

    // Header length accumulator saturates here
    localparam logic [19:0]     ACC_MAX = 20'hFFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_request;
    } t_in_item;

    typedef struct packed {
        logic [3:0] event_kind;
        logic [7:0] byte_out;
    } t_out_item;

endpackage

`default_nettype wire

FILE: rtl/shsp_regs.sv
// APB configuration register for the SCGI header parser (max_header_length).
// Depends on shsp_pkg.
`default_nettype none

module shsp_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [shsp_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    output logic [16:0]                          o_max_len
);
    import shsp_pkg::*;

    logic [16:0] r_max_len;
    logic        wr_hit;

    // address decode: one word at offset 0, byte lanes ignored
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_MAX_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (wr_hit) begin
            r_max_len <= pwdata[16:0];
        end
    end

    // read back, unmapped word reads as zero
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAX_LEN) begin
            prdata = {15'd0, r_max_len};
        end
    end

    assign pready    = 1'b1;
    assign o_max_len = r_max_len;

endmodule

`default_nettype wire

FILE: rtl/shsp_core.sv
// Parser state and per-byte tagging logic for the SCGI header parser.
// Depends on shsp_pkg; state advances on each item taken from the input stage.
`default_nettype none

module shsp_core #(
    parameter int unsigned LENGTH_PREFIX_BYTES = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_fire,
    input  wire shsp_pkg::t_in_item  i_item,
    input  wire logic [16:0]         i_max_len,
    output shsp_pkg::t_out_item      o_result
);
    import shsp_pkg::*;

    localparam int unsigned CW = $clog2(LENGTH_PREFIX_BYTES);
    localparam logic [CW:0] LpbW = (CW+1)'(LENGTH_PREFIX_BYTES);

    // phase codes
    localparam logic [2:0] PH_LEN   = 3'd0;
    localparam logic [2:0] PH_NAME  = 3'd1;
    localparam logic [2:0] PH_VALUE = 3'd2;
    localparam logic [2:0] PH_COMMA = 3'd3;
    localparam logic [2:0] PH_IDLE  = 3'd4;

    logic [2:0]    r_phase, n_phase;
    logic [19:0]   r_acc,   n_acc;
    logic [CW-1:0] r_cnt,   n_cnt;
    logic [16:0]   r_rem,   n_rem;

    logic [2:0]    ph_e;
    logic [19:0]   acc_e;
    logic [CW-1:0] cnt_e;
    logic [16:0]   rem_e;
    logic [16:0]   rem_dec;
    logic [7:0]    b;
    logic [23:0]   acc_sum;
    logic [3:0]    ev;

    assign b = i_item.data_byte;

    // start of request restarts the parser before the byte is handled
    always_comb begin
        ph_e  = i_item.start_of_request ? PH_LEN : r_phase;
        acc_e = i_item.start_of_request ? '0 : r_acc;
        cnt_e = i_item.start_of_request ? '0 : r_cnt;
        rem_e = i_item.start_of_request ? '0 : r_rem;
    end

    assign rem_dec = rem_e - 17'd1;
    // acc*10 + digit, never overflows 24 bits
    assign acc_sum = {1'b0, acc_e, 3'b000} + {3'b000, acc_e, 1'b0}
                   + {16'd0, b - CH_ZERO};

    // per-byte phase update and tagging
    always_comb begin
        n_phase = ph_e;
        n_acc   = acc_e;
        n_cnt   = cnt_e;
        n_rem   = rem_e;
        ev      = EV_IGNORED;
        unique case (ph_e)
            PH_LEN: begin
                if (acc_e > {3'd0, i_max_len}) begin
                    n_phase = PH_IDLE;
                    ev      = EV_ERROR;
                end else if (b == CH_COLON) begin
                    n_rem   = acc_e[16:0];
                    n_phase = PH_NAME;
                    ev      = EV_COLON;
                end else if (b < CH_ZERO || b > CH_NINE) begin
                    n_phase = PH_IDLE;
                    ev      = EV_ERROR;
                end else if ({1'b0, cnt_e} + 1'b1 >= LpbW) begin
                    // the last prefix slot must hold the colon
                    n_phase = PH_IDLE;
                    ev      = EV_ERROR;
                end else begin
                    n_cnt = cnt_e + 1'b1;
                    n_acc = (acc_sum > {4'd0, ACC_MAX}) ? ACC_MAX : acc_sum[19:0];
                    ev    = EV_DIGIT;
                end
            end
            PH_NAME: begin
                // a name needs room for at least one more byte after it
                if (rem_e <= 17'd1) begin
                    n_phase = PH_IDLE;
                    ev      = EV_ERROR;
                end else begin
                    n_rem = rem_dec;
                    if (b == CH_NUL) begin
                        n_phase = PH_VALUE;
                        ev      = EV_NAME_END;
                    end else begin
                        ev = EV_NAME;
                    end
                end
            end
            PH_VALUE: begin
                if (rem_e == 17'd0) begin
                    n_phase = PH_IDLE;
                    ev      = EV_ERROR;
                end else begin
                    n_rem = rem_dec;
                    if (b == CH_NUL) begin
                        n_phase = (rem_dec == 17'd0) ? PH_COMMA : PH_NAME;
                        ev      = EV_VALUE_END;
                    end else if (rem_dec == 17'd0) begin
                        // value ran into the end of the header
                        n_phase = PH_IDLE;
                        ev      = EV_ERROR;
                    end else begin
                        ev = EV_VALUE;
                    end
                end
            end
            PH_COMMA: begin
                n_phase = PH_IDLE;
                ev      = (b == CH_COMMA) ? EV_DONE : EV_ERROR;
            end
            default: begin
                n_phase = PH_IDLE;
                ev      = EV_IGNORED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_rem   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_rem   <= n_rem;
        end
    end

    assign o_result.event_kind = ev;
    assign o_result.byte_out   = b;

endmodule

`default_nettype wire

FILE: rtl/scgi_header_stream_parser.sv
// SCGI header stream parser: input register, tagging core, result register.
// Depends on shsp_pkg, shsp_regs and shsp_core.
//
// Usage:
//   Input channel (i_valid/i_data/o_stall) takes one request byte per item
//   together with start_of_request, which restarts the parser on that byte.
//   Output channel (o_valid/o_data/i_stall) returns one tagged item per input
//   item, in order: event_kind plus the byte itself.
//   APB port sets max_header_length at address 0 (reset 65536); write it only
//   while no items are in flight.
// Path: an accepted item is held in the input register, then in the result
//   register, where it raises o_valid. Throughput: one item per cycle while
//   the result register is not stalled; the per-byte update is a single
//   compare/add step on the parser state, done between the two registers.
// Reset: synchronous, active low. Both stages empty, parser in the length
//   prefix phase with all counters at zero, limit back to 65536.
// Stall: while i_stall holds a full result register, the input register keeps
//   its item and o_stall rises once it is full too; nothing is dropped.
`default_nettype none

module scgi_header_stream_parser #(
    parameter int unsigned LENGTH_PREFIX_BYTES = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input items
    input  wire logic                            i_valid,
    input  wire shsp_pkg::t_in_item              i_data,
    output logic                                 o_stall,
    // result items
    output logic                                 o_valid,
    output shsp_pkg::t_out_item                  o_data,
    input  wire logic                            i_stall,
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [shsp_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import shsp_pkg::*;

    logic        r_s1_valid;
    t_in_item    r_s1_item;
    logic        r_out_valid;
    t_out_item   r_out_item;
    t_out_item   core_result;
    logic [16:0] max_len;
    logic        advance;
    logic        take_in;

    shsp_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_max_len (max_len)
    );

    // input stage moves on when the result register is free or being taken
    assign advance = r_s1_valid && (!r_out_valid || !i_stall);
    assign take_in = i_valid && !o_stall;
    assign o_stall = r_s1_valid && !advance;

    shsp_core #(
        .LENGTH_PREFIX_BYTES (LENGTH_PREFIX_BYTES)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (advance),
        .i_item    (r_s1_item),
        .i_max_len (max_len),
        .o_result  (core_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (take_in) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_s1_item <= i_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= core_result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_item;

endmodule

`default_nettype wire

FILE: rtl/shsp_checker.sv
// Port-level checks for the SCGI header stream parser, bound to the top level.
// Depends on shsp_pkg and scgi_header_stream_parser.
`default_nettype none

module shsp_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_valid,
    input wire shsp_pkg::t_in_item              i_data,
    input wire logic                            o_stall,
    input wire logic                            o_valid,
    input wire shsp_pkg::t_out_item             o_data,
    input wire logic                            i_stall,
    input wire logic                            psel,
    input wire logic                            penable,
    input wire logic                            pwrite,
    input wire logic [shsp_pkg::CFG_ADDR_W-1:0] paddr,
    input wire logic [31:0]                     pwdata,
    input wire logic [31:0]                     prdata,
    input wire logic                            pready
);
    import shsp_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // only defined event codes leave the block
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.event_kind <= EV_IGNORED)
        else $error("undefined event code");

    // colon and done tags only ride on a colon or comma byte
    a_delims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.event_kind == EV_COLON || o_data.event_kind == EV_DONE)
        |-> (o_data.byte_out == CH_COLON || o_data.byte_out == CH_COMMA))
        else $error("delimiter tag on wrong byte");

    // digit tags only on decimal digits
    a_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.event_kind == EV_DIGIT
        |-> o_data.byte_out >= CH_ZERO && o_data.byte_out <= CH_NINE)
        else $error("digit tag on non-digit byte");

endmodule

bind scgi_header_stream_parser shsp_checker u_shsp_checker (.*);

`default_nettype wire

FILE: tb/sv/scgi_header_stream_parser_tb.sv
// Self-checking testbench for scgi_header_stream_parser: byte tagging checked
// against an in-bench parser model under random idle and stall on both sides.
// Depends on shsp_pkg and the scgi_header_stream_parser RTL only.
module scgi_header_stream_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import shsp_pkg::*;

    localparam int unsigned PREFIX_LEN    = 16;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned ITEMS_PER_SET = 400;
    localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_LEN = {REG_MAX_LEN, 2'b00};

    // parser model phases
    localparam logic [2:0] PH_PREFIX = 3'd0;
    localparam logic [2:0] PH_NAME   = 3'd1;
    localparam logic [2:0] PH_VALUE  = 3'd2;
    localparam logic [2:0] PH_COMMA  = 3'd3;
    localparam logic [2:0] PH_IDLE   = 3'd4;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    t_in_item              i_data;
    logic                  o_stall;
    logic                  o_valid;
    t_out_item             o_data;
    logic                  i_stall;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // parser model state
    logic [2:0]   ph;
    logic [19:0]  hdr_len;
    logic [5:0]   digit_cnt;
    logic [16:0]  hdr_left;
    logic [16:0]  len_limit;

    t_out_item    expected_tags[$];
    t_out_item    want;
    logic [7:0]   req_bytes[$];
    int unsigned  items_sent;
    int unsigned  mismatches;
    int unsigned  cycle_cnt;
    int unsigned  hold_cycles;
    bit           tx_burst;
    bit           rx_burst;

    scgi_header_stream_parser #(
        .LENGTH_PREFIX_BYTES(PREFIX_LEN)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Tag one byte and advance the parser state
    function automatic logic [3:0] tag_byte(input logic [7:0] b, input logic restart);
        logic [23:0] scaled;
        logic [3:0]  ev;
        if (restart) begin
            ph        = PH_PREFIX;
            hdr_len   = '0;
            digit_cnt = '0;
            hdr_left  = '0;
        end
        ev = EV_IGNORED;
        case (ph)
            PH_PREFIX: begin
                if (hdr_len > 20'(len_limit)) begin
                    ev = EV_ERROR;
                    ph = PH_IDLE;
                end else if (b == CH_COLON) begin
                    hdr_left = hdr_len[16:0];
                    ph       = PH_NAME;
                    ev       = EV_COLON;
                end else if (b < CH_ZERO || b > CH_NINE) begin
                    ev = EV_ERROR;
                    ph = PH_IDLE;
                end else if (int'(digit_cnt) + 1 >= PREFIX_LEN) begin
                    // this byte had to be the colon
                    ev = EV_ERROR;
                    ph = PH_IDLE;
                end else begin
                    digit_cnt = digit_cnt + 6'd1;
                    scaled    = 24'(hdr_len) * 24'd10 + 24'(b - CH_ZERO);
                    hdr_len   = (scaled > 24'(ACC_MAX)) ? ACC_MAX : scaled[19:0];
                    ev        = EV_DIGIT;
                end
            end
            PH_NAME: begin
                // a name needs at least its NUL plus one value byte
                if (hdr_left <= 17'd1) begin
                    ev = EV_ERROR;
                    ph = PH_IDLE;
                end else begin
                    hdr_left = hdr_left - 17'd1;
                    if (b == CH_NUL) begin
                        ph = PH_VALUE;
                        ev = EV_NAME_END;
                    end else begin
                        ev = EV_NAME;
                    end
                end
            end
            PH_VALUE: begin
                if (hdr_left == 17'd0) begin
                    ev = EV_ERROR;
                    ph = PH_IDLE;
                end else begin
                    hdr_left = hdr_left - 17'd1;
                    if (b == CH_NUL) begin
                        ph = (hdr_left == 17'd0) ? PH_COMMA : PH_NAME;
                        ev = EV_VALUE_END;
                    end else if (hdr_left == 17'd0) begin
                        ev = EV_ERROR;
                        ph = PH_IDLE;
                    end else begin
                        ev = EV_VALUE;
                    end
                end
            end
            PH_COMMA: begin
                ev = (b == CH_COMMA) ? EV_DONE : EV_ERROR;
                ph = PH_IDLE;
            end
            default: begin
                ph = PH_IDLE;
                ev = EV_IGNORED;
            end
        endcase
        return ev;
    endfunction

    // Offer one item after a random gap; predict its tag once accepted
    task automatic send_item(input logic [7:0] b, input logic sor);
        int unsigned gap;
        t_out_item   tag;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= '{data_byte: b, start_of_request: sor};
        do @(posedge i_clk); while (o_stall);
        tag.event_kind = tag_byte(b, sor);
        tag.byte_out   = b;
        expected_tags.push_back(tag);
        items_sent++;
    endtask

    task automatic send_request();
        for (int k = 0; k < req_bytes.size(); k++)
            send_item(req_bytes[k], k == 0);
        req_bytes.delete();
    endtask

    function automatic void push_text(input string s);
        for (int k = 0; k < s.len(); k++)
            req_bytes.push_back(s[k]);
    endfunction

    function automatic void push_zeros(input int unsigned n);
        repeat (n) req_bytes.push_back(CH_ZERO);
    endfunction

    // Stop offering items and let every pending tag come back
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_tags.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write of the length limit, then read it back
    task automatic write_limit(input logic [16:0] limit);
        drain_results();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_LEN;
        pwdata  <= 32'(limit);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        len_limit = limit;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[16:0] !== limit) begin
            $error("max_header_length: expected %0d, got %0d", limit, prdata[16:0]);
            mismatches++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random request: mostly well formed, some with one defect
    function automatic void build_random_request();
        logic [7:0]  body[$];
        string       len_txt;
        int unsigned pairs, max_run, hdr, lead, mode, comma_pos, cut, pos;
        mode    = $urandom_range(0, 9);
        max_run = ($urandom_range(0, 7) == 0) ? 8 : 4;
        pairs   = $urandom_range(0, max_run == 8 ? 8 : 3);
        repeat (pairs) begin
            repeat ($urandom_range(0, max_run)) body.push_back(8'($urandom_range(1, 255)));
            body.push_back(CH_NUL);
            repeat ($urandom_range(0, max_run)) body.push_back(8'($urandom_range(1, 255)));
            body.push_back(CH_NUL);
        end
        hdr = body.size();
        // length off by one
        if (mode == 1)
            hdr = (hdr == 0 || $urandom_range(0, 1) == 1) ? hdr + 1 : hdr - 1;
        len_txt = $sformatf("%0d", hdr);
        if (mode == 4)
            lead = PREFIX_LEN - len_txt.len() - $urandom_range(0, 1);
        else
            lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        push_zeros(lead);
        push_text(len_txt);
        req_bytes.push_back(CH_COLON);
        foreach (body[k]) req_bytes.push_back(body[k]);
        comma_pos = req_bytes.size();
        req_bytes.push_back(CH_COMMA);
        repeat ($urandom_range(0, 2)) req_bytes.push_back(8'($urandom_range(0, 255)));
        case (mode)
            0: begin
                pos = $urandom_range(0, req_bytes.size() - 1);
                req_bytes[pos] = 8'($urandom_range(0, 255));
            end
            2: begin
                cut = $urandom_range(1, req_bytes.size() - 1);
                while (req_bytes.size() > cut) void'(req_bytes.pop_back());
            end
            3: req_bytes[comma_pos] = 8'($urandom_range(0, 255));
            default: ;
        endcase
    endfunction

    // Results sink: random stall per item, long hold-off on request
    initial begin : result_sink
        int unsigned pause;
        i_stall = 1'b0;
        forever begin
            pause = rx_burst ? 0 : $urandom_range(0, 12);
            if (hold_cycles != 0) begin
                pause = hold_cycles;
                hold_cycles = 0;
            end
            if (pause != 0) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (pause - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
        end
    end

    // Compare each accepted result with the oldest predicted tag
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_tags.size() == 0) begin
                $error("unexpected result: event_kind %0d byte_out 0x%02h",
                       o_data.event_kind, o_data.byte_out);
                mismatches++;
            end else begin
                want = expected_tags.pop_front();
                if (o_data.event_kind !== want.event_kind) begin
                    $error("event_kind: expected %0d, got %0d",
                           want.event_kind, o_data.event_kind);
                    mismatches++;
                end
                if (o_data.byte_out !== want.byte_out) begin
                    $error("byte_out: expected 0x%02h, got 0x%02h",
                           want.byte_out, o_data.byte_out);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Every event kind, plus several ways a header can go wrong
    task automatic test_directed_tags();
        push_text("5:AB");
        req_bytes.push_back(CH_NUL);
        push_text("C");
        req_bytes.push_back(CH_NUL);
        push_text(",x");
        send_request();
        // non-digit in the prefix, then ignored
        push_text("1x9");
        send_request();
        // zero length fails on the first header byte
        push_text("0:A");
        send_request();
        // name NUL with no room for a value
        push_text("2:A");
        req_bytes.push_back(CH_NUL);
        send_request();
        // value byte ends the header without a NUL
        push_text("3:A");
        req_bytes.push_back(CH_NUL);
        push_text("B");
        send_request();
        // missing comma
        push_text("3:A");
        req_bytes.push_back(CH_NUL);
        req_bytes.push_back(CH_NUL);
        push_text("!");
        send_request();
        // empty name, all-ones value byte
        push_text("3:");
        req_bytes.push_back(CH_NUL);
        req_bytes.push_back(8'hFF);
        req_bytes.push_back(CH_NUL);
        push_text(",");
        send_request();
    endtask

    // Length limit at its extremes, and the prefix digit count
    task automatic test_limit_extremes();
        push_text("65536:A");
        send_request();
        push_text("65537:");
        send_request();
        write_limit(17'd0);
        push_text("1:");
        send_request();
        push_zeros(PREFIX_LEN - 1);
        push_text(":A");
        send_request();
        push_zeros(PREFIX_LEN);
        push_text(":");
        send_request();
        write_limit(MAX_LEN_RESET);
        push_text("65536:");
        req_bytes.push_back(CH_NUL);
        send_request();
    endtask

    // Receiver holds off while the sender keeps pushing
    task automatic test_backpressure();
        tx_burst    = 1'b1;
        rx_burst    = 1'b0;
        hold_cycles = 80;
        repeat (4) begin
            build_random_request();
            send_request();
        end
        tx_burst = 1'b0;
        drain_results();
    endtask

    // Random requests and noise over several length limits
    task automatic test_random_traffic();
        logic [16:0] limits[5];
        int unsigned target;
        limits = '{17'd65535, 17'd24, 17'd0, 17'($urandom_range(0, 65536)), 17'd65536};
        foreach (limits[s]) begin
            write_limit(limits[s]);
            target = items_sent + ITEMS_PER_SET;
            while (items_sent < target) begin
                tx_burst = ($urandom_range(0, 3) == 0);
                rx_burst = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 6))
                        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end else begin
                    build_random_request();
                    send_request();
                end
            end
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    initial begin
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_data    = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        len_limit = MAX_LEN_RESET;
        ph        = PH_PREFIX;
        hdr_len   = '0;
        digit_cnt = '0;
        hdr_left  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_tags();
        test_limit_extremes();
        test_backpressure();
        test_random_traffic();
        drain_results();

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
rtl/shsp_pkg.sv
rtl/shsp_regs.sv
rtl/shsp_core.sv
rtl/scgi_header_stream_parser.sv
rtl/shsp_checker.sv
tb/sv/scgi_header_stream_parser_tb.sv
